// ===== design/rice_byte_encoder_unit_defines.svh =====
// Assertion macros for the Rice byte encoder.
// Used by the top level; the macros expect signals named clk and rst_n in scope.
`ifndef RICE_BYTE_ENCODER_UNIT_DEFINES_SVH
`define RICE_BYTE_ENCODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RBE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RBE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rbe_pkg.sv =====
// Shared types, constants and helper functions for the Rice byte encoder.
// No dependencies; imported by rbe_packer and rice_byte_encoder_unit.
package rbe_pkg;

    localparam int BYTE_BITS = 8;
    localparam int PEND_BITS = BYTE_BITS - 1;
    localparam int CNT_BITS  = 3;

    localparam logic [3:0] RICE_K_RESET = 4'd6;
    localparam logic [3:0] RICE_K_MIN   = 4'd1;
    localparam logic [3:0] RICE_K_MAX   = 4'd8;

    localparam logic [CNT_BITS-1:0] CNT_FULL = 3'd7;

    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ONES,
        ST_ZERO,
        ST_REM,
        ST_PAD,
        ST_DONE
    } state_t;

    // Request from the sequencer to the bit packer.
    typedef struct packed {
        logic push;
        logic bit_val;
        logic drain;
    } pack_req_t;

    // Status from the bit packer back to the sequencer.
    typedef struct packed {
        logic push_taken;
        logic cnt_zero;
        logic cnt_full;
        logic hold_valid;
    } pack_stat_t;

    // Completed byte handed to the output register.
    typedef struct packed {
        logic                 valid;
        logic [BYTE_BITS-1:0] data;
        logic                 last;
    } pack_emit_t;

    // Clamp the Rice parameter to the supported range.
    function automatic logic [3:0] eff_k(input logic [3:0] k);
        logic [3:0] r;
        if (k < RICE_K_MIN)
        begin
            r = RICE_K_MIN;
        end
        else if (k > RICE_K_MAX)
        begin
            r = RICE_K_MAX;
        end
        else
        begin
            r = k;
        end
        return r;
    endfunction

endpackage

// ===== design/rbe_packer.sv =====
// Bit packer: collects coded bits MSB first into bytes and holds the newest full byte.
// Depends on rbe_pkg.
module rbe_packer (
    input  logic               clk,
    input  logic               rst_n,
    input  rbe_pkg::pack_req_t req,
    input  logic               out_free,
    output rbe_pkg::pack_stat_t stat,
    output rbe_pkg::pack_emit_t emit
);
    import rbe_pkg::*;

    logic [PEND_BITS-1:0] acc_reg, acc_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [BYTE_BITS-1:0] hold_reg, hold_next;
    logic                 hold_valid_reg, hold_valid_next;
    logic                 fills;
    logic                 taken;

    // A push that completes a byte must first move the held byte out.
    assign fills = (cnt_reg == CNT_FULL);
    assign taken = req.push && !(fills && hold_valid_reg && !out_free);

    always_comb
    begin
        acc_next        = acc_reg;
        cnt_next        = cnt_reg;
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        emit.valid      = 1'b0;
        emit.data       = hold_reg;
        emit.last       = 1'b0;
        if (taken)
        begin
            if (fills)
            begin
                emit.valid      = hold_valid_reg;
                hold_next       = {acc_reg, req.bit_val};
                hold_valid_next = 1'b1;
                acc_next        = '0;
                cnt_next        = '0;
            end
            else
            begin
                acc_next = {acc_reg[PEND_BITS-2:0], req.bit_val};
                cnt_next = cnt_reg + 3'd1;
            end
        end
        else if (req.drain && hold_valid_reg && out_free)
        begin
            // The held byte is the final one of this transaction.
            emit.valid      = 1'b1;
            emit.last       = 1'b1;
            hold_valid_next = 1'b0;
        end
    end

    assign stat.push_taken = taken;
    assign stat.cnt_zero   = (cnt_reg == '0);
    assign stat.cnt_full   = fills;
    assign stat.hold_valid = hold_valid_reg;

    // Pending bits and count are architectural state and reset to zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg        <= '0;
            cnt_reg        <= '0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg        <= acc_next;
            cnt_reg        <= cnt_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    // Held byte payload.
    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

endmodule

// ===== design/rice_byte_encoder_unit.sv =====
// Rice byte encoder: codes one bit per cycle unless an output stall holds it. An encode
// codes q one-bits, a stop zero and k remainder bits, then closes; a flush pads the
// pending bits with one-bits to a full byte (none when nothing is pending), then closes.
// The next transaction is accepted once the sequencer is back in the idle state.
// The last byte is registered as the closing state ends; output stalls hold the
// sequencer. Reset clears the sequencer, the pending bits and count, and sets rice_k to 6.
`include "rice_byte_encoder_unit_defines.svh"

module rice_byte_encoder_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [3:0]                    cfg_wr_data,
    input  logic                          sym_valid,
    output logic                          sym_ready,
    input  logic                          cmd,
    input  logic [7:0]                    symbol,
    output logic                          byte_valid,
    input  logic                          byte_ready,
    output logic [rbe_pkg::BYTE_BITS-1:0] packed_byte,
    output logic                          last
);
    import rbe_pkg::*;

    state_t     state_reg, state_next;
    logic [3:0] rice_k_reg;
    logic [7:0] sym_reg, sym_next;
    logic [6:0] ones_left_reg, ones_left_next;
    logic [3:0] rem_left_reg, rem_left_next;
    logic [3:0] rem_idx;
    logic [3:0] k_now;
    logic [7:0] q_now;

    logic                 out_valid_reg;
    logic [BYTE_BITS-1:0] out_byte_reg;
    logic                 out_last_reg;
    logic                 out_free;

    pack_req_t  req;
    pack_stat_t stat;
    pack_emit_t emit;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rice_k_reg <= RICE_K_RESET;
        end
        else if (cfg_wr_en)
        begin
            rice_k_reg <= cfg_wr_data;
        end
    end

    assign k_now    = eff_k(rice_k_reg);
    assign q_now    = symbol >> k_now;
    assign rem_idx  = rem_left_reg - 4'd1;
    assign out_free = !out_valid_reg || byte_ready;
    assign sym_ready = (state_reg == ST_IDLE);

    // Bit sequencer: unary quotient, stop bit, remainder bits, or flush padding.
    always_comb
    begin
        state_next     = state_reg;
        sym_next       = sym_reg;
        ones_left_next = ones_left_reg;
        rem_left_next  = rem_left_reg;
        req.push       = 1'b0;
        req.bit_val    = 1'b1;
        req.drain      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (sym_valid)
                begin
                    sym_next       = symbol;
                    ones_left_next = q_now[6:0];
                    rem_left_next  = k_now;
                    if (cmd == CMD_FLUSH)
                    begin
                        state_next = ST_PAD;
                    end
                    else if (q_now != 8'd0)
                    begin
                        state_next = ST_ONES;
                    end
                    else
                    begin
                        state_next = ST_ZERO;
                    end
                end
            end
            ST_ONES:
            begin
                req.push = 1'b1;
                if (stat.push_taken)
                begin
                    ones_left_next = ones_left_reg - 7'd1;
                    if (ones_left_reg == 7'd1)
                    begin
                        state_next = ST_ZERO;
                    end
                end
            end
            ST_ZERO:
            begin
                req.push    = 1'b1;
                req.bit_val = 1'b0;
                if (stat.push_taken)
                begin
                    state_next = ST_REM;
                end
            end
            ST_REM:
            begin
                req.push    = 1'b1;
                req.bit_val = sym_reg[rem_idx[2:0]];
                if (stat.push_taken)
                begin
                    rem_left_next = rem_left_reg - 4'd1;
                    if (rem_left_reg == 4'd1)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_PAD:
            begin
                // Pad with one-bits until the pending byte is complete.
                if (stat.cnt_zero)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    req.push = 1'b1;
                    if (stat.push_taken && stat.cnt_full)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                req.drain = 1'b1;
                if (!stat.hold_valid || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequencer payload registers.
    always_ff @(posedge clk)
    begin
        sym_reg       <= sym_next;
        ones_left_reg <= ones_left_next;
        rem_left_reg  <= rem_left_next;
    end

    rbe_packer u_packer (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .out_free (out_free),
        .stat     (stat),
        .emit     (emit)
    );

    // Output register: loaded only when empty or being taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (byte_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            out_byte_reg <= emit.data;
            out_last_reg <= emit.last;
        end
    end

    assign byte_valid  = out_valid_reg;
    assign packed_byte = out_byte_reg;
    assign last        = out_last_reg;

    // Checks on the sequencer and output register.
    `RBE_ASSERT_IMP(a_idle_hold_empty, sym_ready, !stat.hold_valid,
                    "held byte left over when a new transaction can start")
    `RBE_ASSERT_IMP(a_no_overwrite, emit.valid, out_free,
                    "output register overwritten before it was taken")
    `RBE_ASSERT_NXT(a_idle_stays, (state_reg == ST_IDLE) && !sym_valid,
                    state_reg == ST_IDLE, "sequencer left idle without a transaction")

endmodule
